// ----- rtl/core/bda_pkg.sv -----
// shared types and constants for the button debounce block
`timescale 1ns / 1ps
`default_nettype none
package bda_pkg;

	localparam int BTN_W      = 8;
	localparam int IDX_W      = 3;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_REPEAT_MODE  = 2'd0,
		REG_SETTLE_TICKS = 2'd1,
		REG_REPEAT_TICKS = 2'd2
	} reg_addr_t;

	localparam logic       RST_REPEAT_MODE  = 1'b0;
	localparam logic [7:0] RST_SETTLE_TICKS = 8'd5;
	localparam logic [7:0] RST_REPEAT_TICKS = 8'd20;

	localparam logic [7:0] BOOST_SMALL_STEP  = 8'd2;
	localparam logic [7:0] BOOST_SMALL_LIMIT = 8'd10;
	localparam logic [7:0] BOOST_LARGE_STEP  = 8'd10;
	localparam logic [8:0] BOOST_MARGIN      = 9'd40;

	typedef struct packed {
		logic       repeat_mode;
		logic [7:0] settle_ticks;
		logic [7:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		op_t              op;
		logic [BTN_W-1:0] buttons;
		logic [IDX_W-1:0] button_index;
	} item_t;

	typedef struct packed {
		logic             pressed;
		logic [BTN_W-1:0] pending_flags;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/bda_if.sv -----
// stream and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface bda_item_if;
	logic                     valid;
	logic                     ready;
	bda_pkg::op_t             op;
	logic [bda_pkg::BTN_W-1:0] buttons;
	logic [bda_pkg::IDX_W-1:0] button_index;

	modport source (output valid, output op, output buttons, output button_index, input ready);
	modport sink   (input valid, input op, input buttons, input button_index, output ready);
endinterface

interface bda_result_if;
	logic                     valid;
	logic                     ready;
	logic                     pressed;
	logic [bda_pkg::BTN_W-1:0] pending_flags;

	modport source (output valid, output pressed, output pending_flags, input ready);
	modport sink   (input valid, input pressed, input pending_flags, output ready);
endinterface

interface bda_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bda_pkg::CFG_ADDR_W-1:0] addr;
	logic [bda_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/bda_cfg_regs.sv -----
// configuration register file
`timescale 1ns / 1ps
`default_nettype none
module bda_cfg_regs (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bda_cfg_if.sink    cfg,
	output bda_pkg::cfg_t regs
);
	import bda_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.repeat_mode  <= RST_REPEAT_MODE;
			regs_q.settle_ticks <= RST_SETTLE_TICKS;
			regs_q.repeat_ticks <= RST_REPEAT_TICKS;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_REPEAT_MODE:  regs_q.repeat_mode  <= cfg.data[0];
				REG_SETTLE_TICKS: regs_q.settle_ticks <= cfg.data[7:0];
				REG_REPEAT_TICKS: regs_q.repeat_ticks <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/bda_engine.sv -----
// debounce and repeat state with its combinational update
`timescale 1ns / 1ps
`default_nettype none
module bda_engine #(
	parameter int NUM_BUTTONS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  bda_pkg::item_t  item,
	input  bda_pkg::cfg_t   regs,
	output bda_pkg::result_t res
);
	import bda_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_CLICK    = 2'd2,
		PH_REPEAT   = 2'd3
	} phase_t;

	localparam logic [BTN_W-1:0] MASK = (NUM_BUTTONS >= BTN_W) ? {BTN_W{1'b1}} :
		BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);

	phase_t           phase_q, phase_d;
	logic [BTN_W-1:0] flags_q, flags_d;
	logic [7:0]       dcount_q, dcount_d;
	logic [7:0]       rcount_q, rcount_d;
	logic [7:0]       boost_q, boost_d;
	logic             hit;
	logic [BTN_W-1:0] pat;
	logic [BTN_W-1:0] sel;
	logic [7:0]       dcount_dec;
	logic             do_repeat;
	logic [7:0]       rcount_dec;
	logic [8:0]       diff;
	logic [7:0]       reload;

	assign pat = item.buttons & MASK;
	assign sel = BTN_W'(1) << item.button_index;

	// repeat interval reload, floored at one
	assign diff   = {1'b0, regs.repeat_ticks} - {1'b0, boost_q};
	assign reload = (diff[8] || diff == 9'd0) ? 8'd1 : diff[7:0];

	assign dcount_dec = dcount_q - 8'd1;
	assign rcount_dec = rcount_q - 8'd1;

	always_comb begin
		phase_d   = phase_q;
		flags_d   = flags_q;
		dcount_d  = dcount_q;
		rcount_d  = rcount_q;
		boost_d   = boost_q;
		hit       = 1'b0;
		do_repeat = 1'b0;
		if (item.op == OP_QUERY) begin
			if (int'(item.button_index) < NUM_BUTTONS && (flags_q & sel) != '0) begin
				flags_d = flags_q & ~sel;
				hit     = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE, PH_DEBOUNCE: begin
					if (pat == '0) begin
						if (phase_q == PH_DEBOUNCE) begin
							dcount_d = regs.settle_ticks;
							phase_d  = PH_IDLE;
						end
					end else if (dcount_dec != 8'd0) begin
						dcount_d = dcount_dec;
						phase_d  = PH_DEBOUNCE;
					end else begin
						dcount_d  = regs.settle_ticks;
						flags_d   = pat;
						phase_d   = regs.repeat_mode ? PH_REPEAT : PH_CLICK;
						do_repeat = regs.repeat_mode;
					end
				end
				PH_CLICK: begin
					if (pat == '0) begin
						phase_d = PH_IDLE;
					end
				end
				PH_REPEAT: begin
					if (pat == '0) begin
						boost_d  = '0;
						rcount_d = regs.repeat_ticks;
						phase_d  = PH_IDLE;
					end else begin
						do_repeat = 1'b1;
					end
				end
				default: ;
			endcase
			if (do_repeat) begin
				if (rcount_dec != 8'd0) begin
					rcount_d = rcount_dec;
				end else begin
					flags_d  = pat;
					rcount_d = reload;
					if (boost_q < BOOST_SMALL_LIMIT) begin
						boost_d = boost_q + BOOST_SMALL_STEP;
					end else if ({1'b0, boost_q} + BOOST_MARGIN < {1'b0, regs.repeat_ticks}) begin
						boost_d = boost_q + BOOST_LARGE_STEP;
					end
				end
			end
		end
	end

	assign res.pressed       = hit;
	assign res.pending_flags = flags_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			flags_q  <= '0;
			dcount_q <= RST_SETTLE_TICKS;
			rcount_q <= RST_REPEAT_TICKS;
			boost_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			flags_q  <= flags_d;
			dcount_q <= dcount_d;
			rcount_q <= rcount_d;
			boost_q  <= boost_d;
		end
	end

	a_boost_only_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		boost_q != '0 |-> phase_q == PH_REPEAT)
		else $error("boost nonzero outside repeat phase");

	a_query_never_sets: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.op == OP_QUERY |=> (flags_q & ~$past(flags_q)) == '0)
		else $error("query set a press flag");

	a_flags_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(flags_q & ~MASK) == '0)
		else $error("flag set for an absent button");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(flags_q) && $stable(phase_q))
		else $error("state changed without a transaction");

endmodule
`default_nettype wire

// ----- rtl/core/button_debounce_auto_repeat.sv -----
// top level of the button debouncer with accelerating auto repeat
//
// item channel: one transaction per tick (op tick, sampled buttons) or per
// query (op query, button_index); every item gives exactly one result.
// result channel: pressed (query hit, flag now cleared; 0 on tick) and
// pending_flags, the latched press flags after the item.
// cfg channel: register writes (repeat mode, settle ticks, repeat ticks),
// always ready; write only while no item is in flight.
// flow: an accepted item is held in the input stage; its result is registered in the
// result stage when that stage is empty or being taken, and offered from then on.
// throughput: one item per cycle while results are taken; the state update is a single
// pass of combinational logic between the input stage and the result register.
// when the result is not taken the input stage holds its item and the
// item channel stays ready until that stage is full.
// reset: flags cleared, phase idle, counters loaded with the reset values
// of the tick registers, both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_auto_repeat #(
	parameter int NUM_BUTTONS = 8
) (
	input wire logic   clk,
	input wire logic   arst_n,
	bda_item_if.sink   item,
	bda_result_if.source result,
	bda_cfg_if.sink    cfg
);
	import bda_pkg::*;

	cfg_t    regs;
	logic    s1_valid_q;
	item_t   item_s1;
	logic    s2_valid_q;
	result_t res_s2;
	result_t res_d;
	logic    advance;
	logic    step;

	assign advance    = !s2_valid_q || result.ready;
	assign step       = s1_valid_q && advance;
	assign item.ready = !s1_valid_q || advance;

	bda_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bda_engine #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.regs   (regs),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op           <= item.op;
			item_s1.buttons      <= item.buttons;
			item_s1.button_index <= item.button_index;
		end
		if (step) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid         = s2_valid_q;
	assign result.pressed       = res_s2.pressed;
	assign result.pending_flags = res_s2.pending_flags;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q)
		else $error("input stage lost a transaction");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && !result.ready |=> s2_valid_q && $stable(res_s2))
		else $error("pending result changed before it was taken");

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// self-checking testbench for the button debouncer with accelerating auto repeat
`timescale 1ns / 1ps
module tb;
	import bda_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef enum logic [1:0] {
		HOLD_IDLE,
		HOLD_DEBOUNCE,
		HOLD_CLICK,
		HOLD_REPEAT
	} hold_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	bda_item_if   item_ch ();
	bda_result_if result_ch ();
	bda_cfg_if    cfg_ch ();

	button_debounce_auto_repeat #(.NUM_BUTTONS(8)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the debouncer state and its settings
	hold_phase_t hold_ph;
	logic [7:0]  latched;
	logic [7:0]  db_left;
	logic [7:0]  rep_left;
	logic [7:0]  boost;
	logic        cfg_mode;
	logic [7:0]  cfg_db;
	logic [7:0]  cfg_rt;

	item_t   item_backlog[$];
	result_t flags_due[$];
	int      items_queued = 0;
	int      items_taken = 0;
	int      errors = 0;
	int      idle_cycles = 0;

	function automatic result_t debounce_step(item_t it);
		result_t    r;
		logic [7:0] pat;
		logic       rep;
		int         reload;
		pat = it.buttons;
		r.pressed = 1'b0;
		if (it.op == OP_TICK) begin
			if (hold_ph == HOLD_IDLE && pat != 8'd0)
				hold_ph = HOLD_DEBOUNCE;
			rep = (hold_ph == HOLD_REPEAT);
			if (hold_ph == HOLD_DEBOUNCE) begin
				if (pat == 8'd0) begin
					db_left = cfg_db;
					hold_ph = HOLD_IDLE;
				end else begin
					db_left = db_left - 8'd1;
					if (db_left == 8'd0) begin
						db_left = cfg_db;
						latched = pat;
						hold_ph = cfg_mode ? HOLD_REPEAT : HOLD_CLICK;
						rep = cfg_mode;
					end
				end
			end else if (hold_ph == HOLD_CLICK && pat == 8'd0) begin
				hold_ph = HOLD_IDLE;
			end
			if (rep) begin
				if (pat == 8'd0) begin
					boost = 8'd0;
					rep_left = cfg_rt;
					hold_ph = HOLD_IDLE;
				end else begin
					rep_left = rep_left - 8'd1;
					if (rep_left == 8'd0) begin
						latched = pat;
						reload = int'(cfg_rt) - int'(boost);
						if (reload < 1)
							reload = 1;
						rep_left = reload[7:0];
						if (boost < BOOST_SMALL_LIMIT)
							boost = boost + BOOST_SMALL_STEP;
						else if (int'(boost) < int'(cfg_rt) - int'(BOOST_MARGIN))
							boost = boost + BOOST_LARGE_STEP;
					end
				end
			end
		end else if (latched[it.button_index]) begin
			latched[it.button_index] = 1'b0;
			r.pressed = 1'b1;
		end
		r.pending_flags = latched;
		return r;
	endfunction

	task automatic report(string msg);
		$display("%0t: mismatch: %s", $time, msg);
		errors++;
	endtask

	// item driver: bursts of random length, random gaps
	always @(posedge clk or negedge arst_n) begin : item_driver
		item_t nxt;
		int    burst_left;
		int    gap_left;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.op <= OP_TICK;
			item_ch.buttons <= '0;
			item_ch.button_index <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				nxt.op = item_ch.op;
				nxt.buttons = item_ch.buttons;
				nxt.button_index = item_ch.button_index;
				flags_due.push_back(debounce_step(nxt));
				items_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					item_ch.valid <= 1'b0;
				end else if (item_backlog.size() != 0) begin
					nxt = item_backlog.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.op <= nxt.op;
					item_ch.buttons <= nxt.buttons;
					item_ch.button_index <= nxt.button_index;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin : result_monitor
		result_t   want;
		int        cyc;
		int        stall_style;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			cyc = 0;
			stall_style = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (flags_due.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = flags_due.pop_front();
					if (result_ch.pressed !== want.pressed)
						report($sformatf("pressed got %b want %b",
							result_ch.pressed, want.pressed));
					if (result_ch.pending_flags !== want.pending_flags)
						report($sformatf("pending_flags got %h want %h",
							result_ch.pending_flags, want.pending_flags));
				end
			end
			cyc++;
			if (cyc % 128 == 0)
				stall_style = $urandom_range(0, 3);
			case (stall_style)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= ($urandom_range(0, 1) == 1);
				2: result_ch.ready <= (cyc % 4 == 3);
				default: result_ch.ready <= (cyc % 16 < 10);
			endcase
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_item(op_t o, logic [7:0] b, logic [2:0] i);
		item_t it;
		it.op = o;
		it.buttons = b;
		it.button_index = i;
		item_backlog.push_back(it);
		items_queued++;
	endtask

	task automatic queue_ticks(logic [7:0] pat, int n);
		for (int k = 0; k < n; k++)
			queue_item(OP_TICK, pat, 3'($urandom()));
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || flags_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_addr_t a, logic [7:0] d);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= a;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (a)
			REG_REPEAT_MODE: cfg_mode = d[0];
			REG_SETTLE_TICKS: cfg_db = d;
			REG_REPEAT_TICKS: cfg_rt = d;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic mode, logic [7:0] db, logic [7:0] rt);
		wait_drained();
		write_reg(REG_REPEAT_MODE, {7'd0, mode});
		write_reg(REG_SETTLE_TICKS, db);
		write_reg(REG_REPEAT_TICKS, rt);
	endtask

	// mostly presses held past debounce, plus cut-short presses, queries and noise
	task automatic mixed_traffic(int budget);
		int         start;
		int         kind;
		int         db_eff;
		int         rt_eff;
		int         extra;
		int         hold;
		logic [7:0] pat;
		start = items_queued;
		db_eff = (cfg_db == 8'd0) ? 256 : int'(cfg_db);
		rt_eff = (cfg_rt == 8'd0) ? 256 : int'(cfg_rt);
		extra = cfg_mode ? ((3 * rt_eff < 150) ? 3 * rt_eff : 150) : 6;
		while (items_queued - start < budget) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				pat = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 9) < 7)
					hold = db_eff + $urandom_range(0, extra);
				else
					hold = $urandom_range(1, db_eff);
				if (hold > 300)
					hold = 300;
				for (int k = 0; k < hold; k++) begin
					if ($urandom_range(0, 9) == 0)
						pat = 8'($urandom_range(1, 255));
					queue_item(OP_TICK, pat, 3'($urandom()));
					if ($urandom_range(0, 11) == 0)
						queue_item(OP_QUERY, 8'($urandom()), 3'($urandom()));
				end
				queue_ticks(8'd0, $urandom_range(1, 3));
				repeat ($urandom_range(0, 4))
					queue_item(OP_QUERY, 8'($urandom()), 3'($urandom()));
			end else if (kind <= 7) begin
				repeat ($urandom_range(1, 8))
					queue_item(OP_QUERY, 8'($urandom()), 3'($urandom()));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					pat = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom());
					queue_item(OP_TICK, pat, 3'($urandom()));
				end
			end
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.op = OP_TICK;
		item_ch.buttons = '0;
		item_ch.button_index = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = REG_REPEAT_MODE;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		cfg_mode = RST_REPEAT_MODE;
		cfg_db = RST_SETTLE_TICKS;
		cfg_rt = RST_REPEAT_TICKS;
		hold_ph = HOLD_IDLE;
		latched = 8'd0;
		db_left = RST_SETTLE_TICKS;
		rep_left = RST_REPEAT_TICKS;
		boost = 8'd0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: query with nothing latched, click press, queries,
		// release during debounce keeps the flags
		queue_item(OP_QUERY, 8'hFF, 3'd7);
		queue_ticks(8'h00, 1);
		queue_ticks(8'h81, 6);
		queue_item(OP_QUERY, 8'h00, 3'd0);
		queue_item(OP_QUERY, 8'h00, 3'd7);
		queue_item(OP_QUERY, 8'hFF, 3'd7);
		queue_ticks(8'h00, 1);
		queue_ticks(8'hFF, 5);
		queue_ticks(8'h00, 1);
		queue_ticks(8'h3C, 2);
		queue_ticks(8'h00, 1);
		queue_item(OP_QUERY, 8'h00, 3'd3);
		queue_item(OP_QUERY, 8'h00, 3'd1);
		queue_item(OP_QUERY, 8'h00, 3'd1);
		mixed_traffic(100);

		// fastest repeat, interval clamps at one
		apply_settings(1'b1, 8'd1, 8'd1);
		mixed_traffic(90);

		// boost grows past the small steps
		apply_settings(1'b1, 8'd3, 8'd60);
		mixed_traffic(110);
		queue_ticks(8'hFF, 10);

		// mode and tick changes while repeat is held; counters do not reload
		apply_settings(1'b0, 8'd255, 8'd255);
		queue_ticks(8'hFF, 40);
		mixed_traffic(120);

		// zero tick registers wrap to 256 ticks
		apply_settings(1'b1, 8'd0, 8'd0);
		queue_ticks(8'h5A, 262);
		queue_ticks(8'h00, 1);
		queue_item(OP_QUERY, 8'h00, 3'd1);
		queue_item(OP_QUERY, 8'h00, 3'd3);

		wait_drained();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
